### rtl/core/edst_pkg.sv
// Shared types, constants and the month-start table for the summer-time pipeline.
`default_nettype none

package edst_pkg;

  // Pipeline depth, from input register to output register
  localparam int unsigned NUM_STG = 7;

  // Field widths
  localparam int unsigned TS_W    = 32;
  localparam int unsigned ADJ_W   = 33;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned SOD_W   = 17;
  localparam int unsigned DOE_W   = 18;
  localparam int unsigned YOE_W   = 9;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned MP_W    = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned WDAY_W  = 3;

  // Time constants
  localparam logic [SOD_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [SOD_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [ADJ_W-1:0] DST_SHIFT     = 33'd3600;
  localparam logic [MDAY_W:0]  LAST_WEEK_DAY = 6'd25;

  // Reciprocals for division by constants (multiply, then shift right)
  localparam logic [25:0] RCP_675  = 26'd50903317;  // x / 675, x < 2^25, shift 35
  localparam logic [16:0] RCP_7    = 17'd74899;     // x / 7, x < 2^16, shift 19
  localparam logic [16:0] RCP_365A = 17'd91930;     // x / 365, x < 2^16, shift 25
  localparam logic [18:0] RCP_365B = 19'd367720;    // x / 365, x < 2^18, shift 27
  localparam logic [9:0]  RCP_100  = 10'd656;       // x / 100, x < 2^9, shift 16
  localparam logic [11:0] RCP_153  = 12'd3427;      // x / 153, x < 2^11, shift 19

  // Calendar constants (era of 400 years counted from March 1)
  localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
  localparam logic [19:0] ERA5_START  = 20'd730485;
  localparam logic [19:0] ERA4_START  = 20'd584388;
  localparam logic [DOE_W-1:0] CENT1  = 18'd36524;
  localparam logic [DOE_W-1:0] CENT2  = 18'd73048;
  localparam logic [DOE_W-1:0] CENT3  = 18'd109572;
  localparam logic [DOE_W-1:0] CENT4  = 18'd146096;

  // Month codes counted from March
  localparam logic [MP_W-1:0] MP_MARCH     = 4'd0;
  localparam logic [MP_W-1:0] MP_APRIL     = 4'd1;
  localparam logic [MP_W-1:0] MP_SEPTEMBER = 4'd6;
  localparam logic [MP_W-1:0] MP_OCTOBER   = 4'd7;

  localparam logic [WDAY_W-1:0] WD_SUNDAY  = 3'd0;

  // Per-stage advance enables for the calendar stages
  typedef struct packed {
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } cal_en_t;

  // Day of year (from March 1) on which month code mp starts
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/core/edst_cal.sv
// Calendar stages: day number to weekday, day of year and month code.
`default_nettype none

module edst_cal (
  input  wire logic                         clk,
  input  wire edst_pkg::cal_en_t            en,
  input  wire logic [edst_pkg::DAYS_W-1:0]  days,
  output logic      [edst_pkg::MP_W-1:0]    mp,
  output logic      [edst_pkg::DOY_W-1:0]   doy,
  output logic      [edst_pkg::WDAY_W-1:0]  wday
);
  import edst_pkg::*;

  // Stage 1 registers
  logic [DAYS_W-1:0] wx1_r,  wx1_nxt;
  logic [12:0]       wq1_r,  wq1_nxt;
  logic [DOE_W-1:0]  doe1_r, doe1_nxt;
  // Stage 2 registers
  logic [DOE_W-1:0]  n2_r,   n2_nxt;
  logic [DOE_W-1:0]  doe2_r;
  logic [WDAY_W-1:0] wd2_r,  wd2_nxt;
  // Stage 3 registers
  logic [YOE_W-1:0]  yoe3_r, yoe3_nxt;
  logic [DOE_W-1:0]  doe3_r;
  logic [WDAY_W-1:0] wd3_r;
  // Stage 4 registers
  logic [DOY_W-1:0]  doy4_r, doy4_nxt;
  logic [WDAY_W-1:0] wd4_r;
  // Stage 5 registers
  logic [MP_W-1:0]   mp5_r,  mp5_nxt;
  logic [DOY_W-1:0]  doy5_r;
  logic [WDAY_W-1:0] wd5_r;

  logic [32:0]       wprod;
  logic [19:0]       z;
  logic [DAYS_W-1:0] wq7;
  logic [32:0]       aprod;
  logic [7:0]        a4y;
  logic [2:0]        bcent;
  logic [DOE_W-1:0]  cera;
  logic [36:0]       yprod;
  logic [18:0]       cprod;
  logic [DOE_W-1:0]  ybase;
  logic [11:0]       mv;
  logic [23:0]       mprod;

  // Stage 1: weekday quotient estimate, day of era
  always_comb begin
    wx1_nxt  = days + 16'd4;
    wprod    = {17'd0, wx1_nxt} * {16'd0, RCP_7};
    wq1_nxt  = wprod[31:19];
    z        = {4'd0, days} + EPOCH_SHIFT;
    doe1_nxt = (z >= ERA5_START) ? DOE_W'(z - ERA5_START) : DOE_W'(z - ERA4_START);
  end

  // Stage 2: weekday remainder, leap-day correction
  always_comb begin
    wq7     = {wq1_r, 3'd0} - {3'd0, wq1_r};
    wd2_nxt = WDAY_W'(wx1_r - wq7);
    aprod   = {17'd0, doe1_r[DOE_W-1:2]} * {16'd0, RCP_365A};
    a4y     = aprod[32:25];
    if (doe1_r >= CENT4) begin
      bcent = 3'd4;
    end else if (doe1_r >= CENT3) begin
      bcent = 3'd3;
    end else if (doe1_r >= CENT2) begin
      bcent = 3'd2;
    end else if (doe1_r >= CENT1) begin
      bcent = 3'd1;
    end else begin
      bcent = 3'd0;
    end
    cera   = (doe1_r == CENT4) ? 18'd1 : 18'd0;
    n2_nxt = doe1_r - {10'd0, a4y} + {15'd0, bcent} - cera;
  end

  // Stage 3: year of era
  always_comb begin
    yprod    = {19'd0, n2_r} * {18'd0, RCP_365B};
    yoe3_nxt = yprod[35:27];
  end

  // Stage 4: day of year
  always_comb begin
    cprod    = {10'd0, yoe3_r} * {9'd0, RCP_100};
    ybase    = ({9'd0, yoe3_r} * 18'd365) + {11'd0, yoe3_r[YOE_W-1:2]}
               - {15'd0, cprod[18:16]};
    doy4_nxt = DOY_W'(doe3_r - ybase);
  end

  // Stage 5: month code
  always_comb begin
    mv      = ({3'd0, doy4_r} * 12'd5) + 12'd2;
    mprod   = {12'd0, mv} * {12'd0, RCP_153};
    mp5_nxt = mprod[22:19];
  end

  // Advance each stage when its enable is high
  always_ff @(posedge clk) begin
    if (en.s1) begin
      wx1_r  <= wx1_nxt;
      wq1_r  <= wq1_nxt;
      doe1_r <= doe1_nxt;
    end
    if (en.s2) begin
      n2_r   <= n2_nxt;
      doe2_r <= doe1_r;
      wd2_r  <= wd2_nxt;
    end
    if (en.s3) begin
      yoe3_r <= yoe3_nxt;
      doe3_r <= doe2_r;
      wd3_r  <= wd2_r;
    end
    if (en.s4) begin
      doy4_r <= doy4_nxt;
      wd4_r  <= wd3_r;
    end
    if (en.s5) begin
      mp5_r  <= mp5_nxt;
      doy5_r <= doy4_r;
      wd5_r  <= wd4_r;
    end
  end

  assign mp   = mp5_r;
  assign doy  = doy5_r;
  assign wday = wd5_r;

endmodule

`default_nettype wire

### rtl/core/eu_dst_timestamp_adjust.sv
// Top level: European summer-time flag and one-hour shift of a Unix timestamp.
//
//   Channel  Ports                                 Direction  Content
//   in       in_valid, in_stall, in_timestamp      to block   UTC seconds, 32 bits
//   out      out_valid, out_stall, out_in_dst,     from block DST flag, shifted time
//            out_adjusted_time
//
// Seven register stages; one item is accepted every cycle unless in_stall is high.
// The reciprocal multipliers set the stage depth.
// Reset clears the stage valid bits only; data registers hold whatever they had.
// A stage advances when it is empty or the stage after it advances, so bubbles
// close up under an output stall; in_stall rises only when every stage is full.
`default_nettype none

module eu_dst_timestamp_adjust (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [edst_pkg::TS_W-1:0]   in_timestamp,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_in_dst,
  output logic      [edst_pkg::ADJ_W-1:0]  out_adjusted_time
);
  import edst_pkg::*;

  logic [NUM_STG-1:0] vld_r, vld_nxt;
  logic [NUM_STG-1:0] en;
  cal_en_t            cal_en;

  logic [TS_W-1:0]    ts_r [NUM_STG-1];
  logic [SOD_W-1:0]   sod_r [1:NUM_STG-2];
  logic [DAYS_W-1:0]  days0_r, days0_nxt;
  logic [SOD_W-1:0]   sod1_nxt;
  logic               dst_r, dst_nxt;
  logic [ADJ_W-1:0]   adj_r, adj_nxt;

  logic [50:0]        dprod;
  logic [32:0]        sprod;
  logic [MP_W-1:0]    mp;
  logic [DOY_W-1:0]   doy;
  logic [WDAY_W-1:0]  wday;
  logic [DOY_W-1:0]   mday_full;
  logic [MDAY_W:0]    last_from;
  logic               last_week;
  logic               early_hour;

  // Stage enables: advance when empty or when the next stage advances
  always_comb begin
    en[NUM_STG-1] = !vld_r[NUM_STG-1] || !out_stall;
    for (int i = NUM_STG-2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
    cal_en = '{s5: en[5], s4: en[4], s3: en[3], s2: en[2], s1: en[1]};
  end

  assign in_stall = !en[0];

  // Valid bits travel with the data
  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NUM_STG; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 0: day number, t / 86400 as (t >> 7) / 675
  always_comb begin
    dprod     = {26'd0, in_timestamp[TS_W-1:7]} * {25'd0, RCP_675};
    days0_nxt = dprod[50:35];
  end

  // Stage 1: second of day
  always_comb begin
    sprod    = {17'd0, days0_r} * {16'd0, SECS_PER_DAY};
    sod1_nxt = SOD_W'(ts_r[0] - sprod[TS_W-1:0]);
  end

  // Timestamp and second-of-day carry
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ts_r[0] <= in_timestamp;
      days0_r <= days0_nxt;
    end
    if (en[1]) begin
      ts_r[1]  <= ts_r[0];
      sod_r[1] <= sod1_nxt;
    end
    for (int i = 2; i < NUM_STG-1; i++) begin
      if (en[i]) begin
        ts_r[i]  <= ts_r[i-1];
        sod_r[i] <= sod_r[i-1];
      end
    end
  end

  edst_cal u_cal (
    .clk  (clk),
    .en   (cal_en),
    .days (days0_r),
    .mp   (mp),
    .doy  (doy),
    .wday (wday)
  );

  // Stage 6: apply the summer-time rule
  always_comb begin
    mday_full  = doy - month_start(mp) + 9'd1;
    last_from  = LAST_WEEK_DAY + {3'd0, wday};
    last_week  = {1'b0, mday_full[MDAY_W-1:0]} >= last_from;
    early_hour = sod_r[NUM_STG-2] < SECS_PER_HOUR;
    if (ts_r[NUM_STG-2] == '0) begin
      dst_nxt = 1'b0;
    end else if (mp inside {[MP_APRIL:MP_SEPTEMBER]}) begin
      dst_nxt = 1'b1;
    end else if (mp == MP_MARCH) begin
      dst_nxt = last_week && !((wday == WD_SUNDAY) && early_hour);
    end else if (mp == MP_OCTOBER) begin
      dst_nxt = !last_week || ((wday == WD_SUNDAY) && early_hour);
    end else begin
      dst_nxt = 1'b0;
    end
    adj_nxt = {1'b0, ts_r[NUM_STG-2]} + (dst_nxt ? DST_SHIFT : '0);
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STG-1]) begin
      dst_r <= dst_nxt;
      adj_r <= adj_nxt;
    end
  end

  assign out_valid         = vld_r[NUM_STG-1];
  assign out_in_dst        = dst_r;
  assign out_adjusted_time = adj_r;

  // Input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled with room in the pipeline");

  // A held result is not dropped
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_adjusted_time))
    else $error("held result lost or changed");

  // Shifted time carries the hour; unshifted time stays in 32 bits
  a_shift_hour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_dst |-> out_adjusted_time >= DST_SHIFT)
    else $error("summer time without the hour shift");

  a_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_dst |-> !out_adjusted_time[ADJ_W-1])
    else $error("winter time result overflows");

endmodule

`default_nettype wire
